[sv/bitonic_record_sorter_defines.svh]
// ----------------------------------------------------------------------------
// Bitonic record sorter assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BITONIC_RECORD_SORTER_DEFINES_SVH
`define BITONIC_RECORD_SORTER_DEFINES_SVH

// same-cycle implication
`define BRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/brs_pkg.sv]
// ----------------------------------------------------------------------------
// Bitonic record sorter package
// Micro-op codes, jump conditions, control/status structs and the microcode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

    // external field width and number of fields per record
    localparam int WORD_W     = 32;
    localparam int NUM_FIELDS = 4;

    // microprogram step counter width
    localparam int STEP_W = 3;

    // datapath operation of one step
    typedef enum logic [2:0] {
        OP_LOAD,   // take one input beat into the store
        OP_INIT,   // reset network loop counters
        OP_READ,   // read both rows of a compare-exchange pair
        OP_WRLO,   // write lower row of the pair
        OP_WRHI,   // write upper row of the pair, advance pair
        OP_ERD,    // read row for emission
        OP_EMIT,   // move row into the output register
        OP_NOP
    } t_op;

    // jump condition of one step
    typedef enum logic [2:0] {
        J_NEVER,
        J_ALWAYS,
        J_MORE_LOAD,
        J_MORE_NET,
        J_MORE_EMIT
    } t_jmp;

    typedef struct packed {
        t_op               op;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uop;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic up;     // compare direction of the current pair
        logic last;   // record counter at its final value
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic in_fire;    // input beat taken
        logic out_load;   // output register loaded
    } t_sts;

    // step addresses
    localparam logic [STEP_W-1:0] ST_LOAD = 3'd0;
    localparam logic [STEP_W-1:0] ST_INIT = 3'd1;
    localparam logic [STEP_W-1:0] ST_READ = 3'd2;
    localparam logic [STEP_W-1:0] ST_WRLO = 3'd3;
    localparam logic [STEP_W-1:0] ST_WRHI = 3'd4;
    localparam logic [STEP_W-1:0] ST_ERD  = 3'd5;
    localparam logic [STEP_W-1:0] ST_EMIT = 3'd6;
    localparam logic [STEP_W-1:0] ST_DONE = 3'd7;

    // microcode ROM
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        unique case (step)
            ST_LOAD: u = '{op: OP_LOAD, jmp: J_MORE_LOAD, target: ST_LOAD};
            ST_INIT: u = '{op: OP_INIT, jmp: J_NEVER,     target: ST_READ};
            ST_READ: u = '{op: OP_READ, jmp: J_NEVER,     target: ST_WRLO};
            ST_WRLO: u = '{op: OP_WRLO, jmp: J_NEVER,     target: ST_WRHI};
            ST_WRHI: u = '{op: OP_WRHI, jmp: J_MORE_NET,  target: ST_READ};
            ST_ERD:  u = '{op: OP_ERD,  jmp: J_NEVER,     target: ST_EMIT};
            ST_EMIT: u = '{op: OP_EMIT, jmp: J_MORE_EMIT, target: ST_ERD};
            ST_DONE: u = '{op: OP_NOP,  jmp: J_ALWAYS,    target: ST_LOAD};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[sv/brs_in_if.sv]
// ----------------------------------------------------------------------------
// Record input channel
// Valid/ready channel carrying one unsorted record per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_word;
    logic [31:0] payload_one;
    logic [31:0] payload_two;
    logic [31:0] payload_three;

    modport source (
        output valid, key_word, payload_one, payload_two, payload_three,
        input  ready
    );
    modport sink (
        input  valid, key_word, payload_one, payload_two, payload_three,
        output ready
    );
endinterface

`default_nettype wire

[sv/brs_out_if.sv]
// ----------------------------------------------------------------------------
// Record output channel
// Valid/ready channel carrying one sorted record per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_key;
    logic [31:0] out_payload_one;
    logic [31:0] out_payload_two;
    logic [31:0] out_payload_three;
    logic        final_record;

    modport source (
        output valid, out_key, out_payload_one, out_payload_two, out_payload_three,
               final_record,
        input  ready
    );
    modport sink (
        input  valid, out_key, out_payload_one, out_payload_two, out_payload_three,
               final_record,
        output ready
    );
endinterface

`default_nettype wire

[sv/brs_useq.sv]
// ----------------------------------------------------------------------------
// Bitonic record sorter microsequencer
// Step counter over the microcode ROM, record counter and network loop counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitonic_record_sorter_defines.svh"

module brs_useq #(
    parameter int NUM_RECORDS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_sort_ascending,
    input  wire brs_pkg::t_sts                  i_sts,
    output brs_pkg::t_ctl                       o_ctl,
    output logic [$clog2(NUM_RECORDS)-1:0]      o_addr_a,
    output logic [$clog2(NUM_RECORDS)-1:0]      o_addr_b
);
    import brs_pkg::*;

    localparam int L      = $clog2(NUM_RECORDS);
    localparam int PAIR_W = (L > 1) ? L - 1 : 1;
    localparam int KLOG_W = $clog2(L + 1);
    localparam int JLOG_W = (L > 1) ? $clog2(L) : 1;

    localparam logic [PAIR_W-1:0] PAIR_LAST = PAIR_W'(NUM_RECORDS / 2 - 1);
    localparam logic [L-1:0]      CNT_LAST  = L'(NUM_RECORDS - 1);
    localparam logic [KLOG_W-1:0] KLOG_TOP  = KLOG_W'(L);

    logic [STEP_W-1:0] r_step, n_step;
    logic [L-1:0]      r_cnt,  n_cnt;
    logic [KLOG_W-1:0] r_klog, n_klog;
    logic [JLOG_W-1:0] r_jlog, n_jlog;
    logic [PAIR_W-1:0] r_pair, n_pair;

    t_uop         w_uop;
    logic [L-1:0] w_lo;
    logic [L-1:0] w_hi;
    logic [L-1:0] w_bitj;
    logic         w_kbit;
    logic         w_up;
    logic         w_last;
    logic         w_net_done;
    logic         w_hold;
    logic         w_jump;

    assign w_uop = ucode(r_step);

    // lower index of the pair: pair number with a zero inserted at bit jlog
    genvar gb;
    generate
        for (gb = 0; gb < L; gb++) begin : g_lo
            if (gb == 0) begin : g_b0
                assign w_lo[gb] = (r_jlog == '0) ? 1'b0 : r_pair[0];
            end else if (gb == L - 1) begin : g_top
                assign w_lo[gb] = (r_jlog == JLOG_W'(gb)) ? 1'b0 : r_pair[gb-1];
            end else begin : g_mid
                assign w_lo[gb] = (JLOG_W'(gb) < r_jlog)  ? r_pair[gb] :
                                  (JLOG_W'(gb) == r_jlog) ? 1'b0 : r_pair[gb-1];
            end
        end
    endgenerate

    assign w_bitj = L'(1) << r_jlog;
    assign w_hi   = w_lo | w_bitj;

    // block direction: bit klog of the index, top level from the register
    always_comb begin
        w_kbit = 1'b0;
        for (int b = 0; b < L; b++) begin
            if (r_klog == KLOG_W'(b)) begin
                w_kbit = w_lo[b];
            end
        end
    end

    assign w_up = ~w_kbit ^ ((r_klog == KLOG_TOP) & ~i_sort_ascending);

    assign w_last     = (r_cnt == CNT_LAST);
    assign w_net_done = (r_pair == PAIR_LAST) && (r_jlog == '0) && (r_klog == KLOG_TOP);

    // next state of step and loop counters
    always_comb begin
        n_step = r_step;
        n_cnt  = r_cnt;
        n_klog = r_klog;
        n_jlog = r_jlog;
        n_pair = r_pair;
        w_hold = 1'b0;
        w_jump = 1'b0;

        unique case (w_uop.op)
            OP_LOAD: begin
                w_hold = ~i_sts.in_fire;
                if (i_sts.in_fire) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            OP_INIT: begin
                n_klog = KLOG_W'(1);
                n_jlog = '0;
                n_pair = '0;
            end
            OP_WRHI: begin
                if (r_pair != PAIR_LAST) begin
                    n_pair = r_pair + 1'b1;
                end else begin
                    n_pair = '0;
                    if (r_jlog != '0) begin
                        n_jlog = r_jlog - 1'b1;
                    end else if (r_klog != KLOG_TOP) begin
                        n_klog = r_klog + 1'b1;
                        n_jlog = JLOG_W'(r_klog);
                    end
                end
            end
            OP_EMIT: begin
                w_hold = ~i_sts.out_load;
                if (i_sts.out_load) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            OP_READ, OP_WRLO, OP_ERD, OP_NOP: begin
            end
        endcase

        unique case (w_uop.jmp)
            J_NEVER:     w_jump = 1'b0;
            J_ALWAYS:    w_jump = 1'b1;
            J_MORE_LOAD: w_jump = ~w_last;
            J_MORE_NET:  w_jump = ~w_net_done;
            J_MORE_EMIT: w_jump = ~w_last;
            default:     w_jump = 1'b0;
        endcase

        if (!w_hold) begin
            n_step = w_jump ? w_uop.target : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_LOAD;
            r_cnt  <= '0;
            r_klog <= '0;
            r_jlog <= '0;
            r_pair <= '0;
        end else begin
            r_step <= n_step;
            r_cnt  <= n_cnt;
            r_klog <= n_klog;
            r_jlog <= n_jlog;
            r_pair <= n_pair;
        end
    end

    // control out
    assign o_ctl.op   = w_uop.op;
    assign o_ctl.up   = w_up;
    assign o_ctl.last = w_last;
    assign o_addr_a   = ((w_uop.op == OP_LOAD) || (w_uop.op == OP_ERD) ||
                         (w_uop.op == OP_EMIT)) ? r_cnt : w_lo;
    assign o_addr_b   = w_hi;

    // checks
    `BRS_ASSERT_IMP(a_pair_split, i_clk, i_rst_n, w_uop.op == OP_READ,
                    (w_lo & w_bitj) == '0, "pair lower index has partner bit set")
    `BRS_ASSERT_NXT(a_load_to_sort, i_clk, i_rst_n,
                    (w_uop.op == OP_LOAD) && i_sts.in_fire && w_last,
                    w_uop.op == OP_INIT, "sort did not start after last record")
    `BRS_ASSERT_IMP(a_emit_from_zero, i_clk, i_rst_n, w_uop.op == OP_INIT,
                    r_cnt == '0, "record counter not wrapped at sort start")

endmodule

`default_nettype wire

[sv/brs_datapath.sv]
// ----------------------------------------------------------------------------
// Bitonic record sorter datapath
// Record memory, compare-exchange unit, input packing and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bitonic_record_sorter_defines.svh"

module brs_datapath #(
    parameter int NUM_RECORDS = 16,
    parameter int NUM_ATTRS   = 4,
    parameter int ATTR_WIDTH  = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    brs_in_if.sink                          i_rec,
    brs_out_if.source                       o_rec,
    input  wire brs_pkg::t_ctl              i_ctl,
    input  wire logic [$clog2(NUM_RECORDS)-1:0] i_addr_a,
    input  wire logic [$clog2(NUM_RECORDS)-1:0] i_addr_b,
    output brs_pkg::t_sts                   o_sts
);
    import brs_pkg::*;

    localparam int L     = $clog2(NUM_RECORDS);
    localparam int ROW_W = NUM_ATTRS * ATTR_WIDTH;

    logic [ROW_W-1:0] r_mem [NUM_RECORDS];
    logic [ROW_W-1:0] r_rd_a;
    logic [ROW_W-1:0] r_rd_b;
    logic [ROW_W-1:0] r_out_row;
    logic             r_out_final;
    logic             r_out_valid, n_out_valid;

    logic [WORD_W-1:0] w_in_word  [NUM_FIELDS];
    logic [WORD_W-1:0] w_out_word [NUM_FIELDS];
    logic [ROW_W-1:0]  w_in_row;
    logic [ATTR_WIDTH-1:0] w_key_a;
    logic [ATTR_WIDTH-1:0] w_key_b;
    logic              w_swap;
    logic              w_in_fire;
    logic              w_out_load;
    logic              w_we;
    logic [L-1:0]      w_waddr;
    logic [ROW_W-1:0]  w_wdata;

    // input beat into a stored row, attributes truncated
    assign w_in_word[0] = i_rec.key_word;
    assign w_in_word[1] = i_rec.payload_one;
    assign w_in_word[2] = i_rec.payload_two;
    assign w_in_word[3] = i_rec.payload_three;

    genvar gj;
    generate
        for (gj = 0; gj < NUM_ATTRS; gj++) begin : g_pack
            assign w_in_row[gj*ATTR_WIDTH +: ATTR_WIDTH] = w_in_word[gj][ATTR_WIDTH-1:0];
        end
        // output words, zero for attributes not kept
        for (gj = 0; gj < NUM_FIELDS; gj++) begin : g_unpack
            if (gj < NUM_ATTRS) begin : g_kept
                assign w_out_word[gj] = WORD_W'(r_out_row[gj*ATTR_WIDTH +: ATTR_WIDTH]);
            end else begin : g_zero
                assign w_out_word[gj] = '0;
            end
        end
    endgenerate

    // handshakes
    assign i_rec.ready      = (i_ctl.op == OP_LOAD);
    assign w_in_fire        = i_rec.valid & (i_ctl.op == OP_LOAD);
    assign w_out_load       = (i_ctl.op == OP_EMIT) & (~r_out_valid | o_rec.ready);
    assign o_sts.in_fire    = w_in_fire;
    assign o_sts.out_load   = w_out_load;

    // compare-exchange: strict greater-than, equal keys stay
    assign w_key_a = r_rd_a[ATTR_WIDTH-1:0];
    assign w_key_b = r_rd_b[ATTR_WIDTH-1:0];
    assign w_swap  = i_ctl.up ? (w_key_a > w_key_b) : (w_key_b > w_key_a);

    // single write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = i_addr_a;
        w_wdata = r_rd_b;
        unique case (i_ctl.op)
            OP_LOAD: begin
                w_we    = w_in_fire;
                w_wdata = w_in_row;
            end
            OP_WRLO: begin
                w_we    = w_swap;
                w_wdata = r_rd_b;
            end
            OP_WRHI: begin
                w_we    = w_swap;
                w_waddr = i_addr_b;
                w_wdata = r_rd_a;
            end
            OP_INIT, OP_READ, OP_ERD, OP_EMIT, OP_NOP: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        if ((i_ctl.op == OP_READ) || (i_ctl.op == OP_ERD)) begin
            r_rd_a <= r_mem[i_addr_a];
            r_rd_b <= r_mem[i_addr_b];
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rec.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_row   <= r_rd_a;
            r_out_final <= i_ctl.last;
        end
    end

    assign o_rec.valid             = r_out_valid;
    assign o_rec.out_key           = w_out_word[0];
    assign o_rec.out_payload_one   = w_out_word[1];
    assign o_rec.out_payload_two   = w_out_word[2];
    assign o_rec.out_payload_three = w_out_word[3];
    assign o_rec.final_record      = r_out_final;

    // checks
    `BRS_ASSERT_NXT(a_swap_pair, i_clk, i_rst_n, (i_ctl.op == OP_WRLO) && w_swap,
                    (i_ctl.op == OP_WRHI) && w_swap,
                    "pair swap decision changed between writes")
    `BRS_ASSERT_IMP(a_no_write_on_emit, i_clk, i_rst_n, w_we,
                    (i_ctl.op == OP_LOAD) || (i_ctl.op == OP_WRLO) || (i_ctl.op == OP_WRHI),
                    "memory written outside load or exchange")
    `BRS_ASSERT_NXT(a_final_closes, i_clk, i_rst_n,
                    r_out_valid && r_out_final && o_rec.ready && (i_ctl.op != OP_EMIT),
                    !r_out_valid, "beat emitted after final record")

endmodule

`default_nettype wire

[sv/bitonic_record_sorter.sv]
// ----------------------------------------------------------------------------
// Bitonic record sorter
// Loads a set of records, sorts them by key with a bitonic network, emits them.
// ----------------------------------------------------------------------------
// Usage:
//   i_rec takes one record per beat (key plus three payload words). After
//   NUM_RECORDS beats the input stalls (ready low) while the set is sorted,
//   then o_rec delivers the set in key order, final_record high on the last
//   beat, and i_rec opens again for the next set.
//   i_cfg_wr_en/i_cfg_wr_data write the direction bit (1 ascending, 0
//   descending); write it only while no set is in flight.
// Steps per set (L = log2(NUM_RECORDS)):
//   load    one beat a cycle while i_rec.valid is high
//   sort    an init step and (NUM_RECORDS/2)*L*(L+1)/2 compare-exchanges; each
//           is one read step and two write steps on the single memory write port
//   emit    per beat a memory read step, then an output register step; then a
//           closing step returns to loading.
// Reset: sequencer back to loading, record count cleared, direction ascending,
//   output empty. Record memory is not cleared.
// Stall: a low o_rec.ready holds the output register; the sequencer waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitonic_record_sorter #(
    parameter int NUM_RECORDS = 16,
    parameter int NUM_ATTRS   = 4,
    parameter int ATTR_WIDTH  = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    brs_in_if.sink    i_rec,
    brs_out_if.source o_rec,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data
);
    import brs_pkg::*;

    localparam int L = $clog2(NUM_RECORDS);

    logic         r_sort_ascending;
    t_ctl         w_ctl;
    t_sts         w_sts;
    logic [L-1:0] w_addr_a;
    logic [L-1:0] w_addr_b;

    // direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_ascending <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_sort_ascending <= i_cfg_wr_data;
        end
    end

    brs_useq #(
        .NUM_RECORDS (NUM_RECORDS)
    ) u_useq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sort_ascending (r_sort_ascending),
        .i_sts            (w_sts),
        .o_ctl            (w_ctl),
        .o_addr_a         (w_addr_a),
        .o_addr_b         (w_addr_b)
    );

    brs_datapath #(
        .NUM_RECORDS (NUM_RECORDS),
        .NUM_ATTRS   (NUM_ATTRS),
        .ATTR_WIDTH  (ATTR_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (i_rec),
        .o_rec    (o_rec),
        .i_ctl    (w_ctl),
        .i_addr_a (w_addr_a),
        .i_addr_b (w_addr_b),
        .o_sts    (w_sts)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Bitonic record sorter testbench
// Feeds sets of 16 records through the valid/ready input channel, rebuilds
// the sorted set with its own bitonic network, and checks every output beat
// field by field. It covers both sort directions, random gaps on the input,
// random stalls and one long hold-off on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import brs_pkg::*;

    localparam int SET_SIZE    = 16;
    localparam int SETS_PER_PH = 6;
    localparam int NUM_PHASES  = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] pay_one;
        logic [WORD_W-1:0] pay_two;
        logic [WORD_W-1:0] pay_three;
    } t_rec;

    typedef struct packed {
        t_rec body;
        logic last;
    } t_sorted;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    brs_in_if  in_ch ();
    brs_out_if out_ch ();

    bitonic_record_sorter #(
        .NUM_RECORDS(SET_SIZE)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (in_ch),
        .o_rec         (out_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5ns i_clk = ~i_clk;

    // records waiting to be offered, and sorted records waiting to come out
    t_rec    pending_recs[$];
    t_sorted sorted_recs[$];

    // predictor state: rows of the set being loaded and the direction bit
    t_rec    set_rows[SET_SIZE];
    int      rows_loaded = 0;
    logic    sort_up = 1'b1;

    t_rec    offered;
    int      gap_left;
    int      stall_left;
    int      hold_left;
    logic    hold_used;
    logic    hold_armed = 1'b0;
    logic    quiet_tail = 1'b0;
    int      mismatch_count = 0;
    int      cycle_count = 0;

    // store one accepted record; on the last one of a set, sort and queue
    task automatic absorb_record(input t_rec rec);
        int   k;
        int   j;
        int   i;
        int   l;
        logic up;
        logic swap;
        t_rec tmp;
        t_sorted res;
        set_rows[rows_loaded] = rec;
        rows_loaded++;
        if (rows_loaded == SET_SIZE) begin
            // iterative form of the recursive network; stages keep their order
            for (k = 2; k <= SET_SIZE; k = k * 2) begin
                for (j = k / 2; j > 0; j = j / 2) begin
                    for (i = 0; i < SET_SIZE; i++) begin
                        l = i ^ j;
                        if (l > i) begin
                            up   = (k == SET_SIZE) ? sort_up : ((i & k) == 0);
                            swap = up ? (set_rows[i].key > set_rows[l].key)
                                      : (set_rows[l].key > set_rows[i].key);
                            if (swap) begin
                                tmp         = set_rows[i];
                                set_rows[i] = set_rows[l];
                                set_rows[l] = tmp;
                            end
                        end
                    end
                end
            end
            for (i = 0; i < SET_SIZE; i++) begin
                res.body = set_rows[i];
                res.last = (i == SET_SIZE - 1);
                sorted_recs.push_back(res);
            end
            rows_loaded = 0;
        end
    endtask

    task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // mostly random words, with a share of extremes and single-bit patterns;
    // a nonzero spread keeps values small so keys collide
    function automatic logic [WORD_W-1:0] pick_word(input int unsigned spread);
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = 32'd1 << $urandom_range(0, 31);
            3: w = ~(32'd1 << $urandom_range(0, 31));
            default: w = (spread == 0) ? $urandom : $urandom_range(0, spread);
        endcase
        return w;
    endfunction

    // input driver: one beat offered at a time, random gap bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_record(offered);
            end
            if (in_ch.valid && !in_ch.ready) begin
                // beat still on offer, hold it
            end else if (gap_left != 0) begin
                in_ch.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end else if (!quiet_tail && pending_recs.size() != 0
                         && $urandom_range(0, 5) == 0) begin
                in_ch.valid <= 1'b0;
                gap_left    <= $urandom_range(0, 2);
            end else if (pending_recs.size() != 0) begin
                offered               = pending_recs.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.key_word      <= offered.key;
                in_ch.payload_one   <= offered.pay_one;
                in_ch.payload_two   <= offered.pay_two;
                in_ch.payload_three <= offered.pay_three;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output monitor: checks each beat, random stall bursts, long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (sorted_recs.size() == 0) begin
                    $display("%0t: record beat with none expected, actual key %h",
                             $time, out_ch.out_key);
                    mismatch_count++;
                end else begin
                    t_sorted want;
                    want = sorted_recs.pop_front();
                    check_field("out_key", want.body.key, out_ch.out_key);
                    check_field("out_payload_one", want.body.pay_one,
                                out_ch.out_payload_one);
                    check_field("out_payload_two", want.body.pay_two,
                                out_ch.out_payload_two);
                    check_field("out_payload_three", want.body.pay_three,
                                out_ch.out_payload_three);
                    check_field("final_record", WORD_W'(want.last),
                                WORD_W'(out_ch.final_record));
                end
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left   <= $urandom_range(0, 2);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // one long receiver hold-off, started on the first output beat once armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_used && out_ch.valid) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // wait until every record went in and every sorted record came out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_recs.size() != 0 || in_ch.valid || sorted_recs.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_direction(input logic up);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= up;
        sort_up        = up;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        t_rec        rec;
        int          ph;
        int          s;
        int          n;
        int unsigned key_spread;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.key_word      = '0;
        in_ch.payload_one   = '0;
        in_ch.payload_two   = '0;
        in_ch.payload_three = '0;
        out_ch.ready        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed set under the reset direction: key extremes, sign-bit
        // neighbors and runs of equal keys told apart by their payloads
        for (n = 0; n < SET_SIZE; n++) begin
            case (n)
                0, 10:           rec.key = '0;
                1, 11:           rec.key = '1;
                2:               rec.key = 32'h8000_0000;
                3:               rec.key = 32'h7fff_ffff;
                4:               rec.key = 32'h0000_0001;
                5:               rec.key = 32'hffff_fffe;
                6, 7, 8, 9:      rec.key = 32'h0000_1234;
                default:         rec.key = 32'h5555_5555;
            endcase
            rec.pay_one   = n;
            rec.pay_two   = n[0] ? '1 : '0;
            rec.pay_three = n[0] ? 32'haaaa_aaaa : 32'h5555_5555;
            pending_recs.push_back(rec);
        end

        // random phases, direction flipping each time
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            set_direction(ph[0]);
            if (ph == 1) hold_armed = 1'b1;
            if (ph == NUM_PHASES - 1) quiet_tail = 1'b1;
            for (s = 0; s < SETS_PER_PH; s++) begin
                case ($urandom_range(0, 2))
                    0:       key_spread = 0;
                    1:       key_spread = 3;
                    default: key_spread = 255;
                endcase
                for (n = 0; n < SET_SIZE; n++) begin
                    rec.key       = pick_word(key_spread);
                    rec.pay_one   = pick_word(0);
                    rec.pay_two   = pick_word(0);
                    rec.pay_three = pick_word(0);
                    pending_recs.push_back(rec);
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/brs_pkg.sv
sv/brs_in_if.sv
sv/brs_out_if.sv
sv/brs_useq.sv
sv/brs_datapath.sv
sv/bitonic_record_sorter.sv
dv/tb_top.sv
